FILE: rtl/spgd_pkg.sv
// Shared constants for the symmetric prime gap detector.
// Used by every module in rtl/; depends on nothing.
package spgd_pkg;

  // Default window size in gaps and width of a stored gap
  localparam int DEF_WINDOW_GAPS = 32;
  localparam int DEF_GAP_BITS    = 16;

  // Field widths of the stream items
  localparam int PRIME_BITS   = 64;
  localparam int PATTERN_BITS = 6;

  // Mirrored gap pairs the even chain must match before its first run is reported; the odd chain needs one more
  localparam int INNER_SPAN = 7;
  // Gap count of the shortest even-centred run
  localparam int BASE_GAPS  = 15;

  // Entries in the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_LVL_BITS = $clog2(QUEUE_DEPTH + 1);

endpackage

FILE: rtl/spgd_front.sv
// Front part: accepts primes, keeps the prime and gap windows and flags matches.
// Pushes one queue entry per prime that yields runs. Depends on spgd_pkg.
module spgd_front #(
  parameter int WINDOW_GAPS = spgd_pkg::DEF_WINDOW_GAPS,
  parameter int GAP_BITS    = spgd_pkg::DEF_GAP_BITS,
  parameter int RUNS        = WINDOW_GAPS / 2 - spgd_pkg::INNER_SPAN
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [spgd_pkg::PRIME_BITS-1:0]        in_prime,
  input  logic                                   in_restart,
  input  logic [spgd_pkg::QUEUE_LVL_BITS-1:0]    q_level,
  output logic                                   q_push,
  output logic [RUNS-1:0]                        q_even,
  output logic [RUNS-1:0]                        q_odd,
  output logic [RUNS*spgd_pkg::PRIME_BITS-1:0]   q_primes
);

  localparam int CENTRE    = WINDOW_GAPS / 2 - 1;
  localparam int FILL_BITS = $clog2(WINDOW_GAPS + 2);
  localparam int PB        = spgd_pkg::PRIME_BITS;
  localparam int SPAN      = spgd_pkg::INNER_SPAN;

  logic [PB-1:0]        prime_win_r [WINDOW_GAPS+1];
  logic [PB-1:0]        prime_win_nxt [WINDOW_GAPS+1];
  logic [GAP_BITS-1:0]  gap_win_r [WINDOW_GAPS];
  logic [GAP_BITS-1:0]  gap_win_nxt [WINDOW_GAPS];
  logic [FILL_BITS-1:0] fill_r, fill_nxt;
  logic                 pend_r, pend_nxt;
  logic                 accept;
  logic [PB-1:0]        diff;
  logic [GAP_BITS-1:0]  gap_sat;
  logic [CENTRE:0]      eq_even;
  logic [CENTRE:0]      eq_odd;
  logic [RUNS-1:0]      even_run;
  logic [RUNS-1:0]      odd_run;
  logic                 lvl_room;

  // Hold input while the queue could not take a pending entry
  assign lvl_room  = ({1'b0, q_level} + {{spgd_pkg::QUEUE_LVL_BITS{1'b0}}, pend_r})
                     < (spgd_pkg::QUEUE_LVL_BITS + 1)'(spgd_pkg::QUEUE_DEPTH);
  assign in_tready = lvl_room;
  assign accept    = in_tvalid && in_tready;

  // Saturate the new gap to the stored width
  assign diff    = in_prime - prime_win_r[WINDOW_GAPS];
  assign gap_sat = (diff[PB-1:GAP_BITS] != '0) ? {GAP_BITS{1'b1}} : diff[GAP_BITS-1:0];

  // Shift the windows on every accepted prime, or clear them on a restart
  always_comb begin
    for (int i = 0; i < WINDOW_GAPS + 1; i++) prime_win_nxt[i] = prime_win_r[i];
    for (int i = 0; i < WINDOW_GAPS; i++) gap_win_nxt[i] = gap_win_r[i];
    fill_nxt = fill_r;
    if (accept) begin
      if (in_restart) begin
        for (int i = 0; i < WINDOW_GAPS; i++) prime_win_nxt[i] = '0;
        for (int i = 0; i < WINDOW_GAPS; i++) gap_win_nxt[i] = '0;
        fill_nxt = FILL_BITS'(1);
      end else begin
        for (int i = 0; i < WINDOW_GAPS; i++) prime_win_nxt[i] = prime_win_r[i+1];
        if (fill_r != '0) begin
          for (int i = 0; i < WINDOW_GAPS - 1; i++) gap_win_nxt[i] = gap_win_r[i+1];
          gap_win_nxt[WINDOW_GAPS-1] = gap_sat;
        end
        if (fill_r != FILL_BITS'(WINDOW_GAPS + 1)) fill_nxt = fill_r + 1'b1;
      end
      prime_win_nxt[WINDOW_GAPS] = in_prime;
    end
  end

  // Flag a full window for classification in the next cycle
  assign pend_nxt = accept && (fill_nxt == FILL_BITS'(WINDOW_GAPS + 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pend_r <= 1'b0;
      for (int i = 0; i < WINDOW_GAPS + 1; i++) prime_win_r[i] <= '0;
      for (int i = 0; i < WINDOW_GAPS; i++) gap_win_r[i] <= '0;
    end else begin
      fill_r <= fill_nxt;
      pend_r <= pend_nxt;
      for (int i = 0; i < WINDOW_GAPS + 1; i++) prime_win_r[i] <= prime_win_nxt[i];
      for (int i = 0; i < WINDOW_GAPS; i++) gap_win_r[i] <= gap_win_nxt[i];
    end
  end

  // Compare mirrored gap pairs around the centre
  always_comb begin
    eq_even[0] = 1'b1;
    for (int j = 1; j <= CENTRE; j++)
      eq_even[j] = (gap_win_r[CENTRE-j] == gap_win_r[CENTRE+j]);
    for (int j = 0; j <= CENTRE; j++)
      eq_odd[j] = (gap_win_r[CENTRE-j] == gap_win_r[CENTRE+1+j]);
  end

  // Turn the compares into one flag per reportable run length
  always_comb begin
    even_run[0] = &eq_even[SPAN:1];
    odd_run[0]  = &eq_odd[SPAN:0];
    for (int k = 1; k < RUNS; k++) begin
      even_run[k] = even_run[k-1] && eq_even[SPAN+k];
      odd_run[k]  = odd_run[k-1] && eq_odd[SPAN+k];
    end
  end

  // Snapshot the start primes, shortest run first
  always_comb begin
    for (int k = 0; k < RUNS; k++) q_primes[k*PB +: PB] = prime_win_r[CENTRE-SPAN-k];
  end

  assign q_even = even_run;
  assign q_odd  = odd_run;
  assign q_push = pend_r && (even_run[0] || odd_run[0]);

endmodule

FILE: rtl/spgd_queue.sv
// Short queue that decouples the front classifier from the result sequencer.
// Depends on spgd_pkg for depth and pointer widths.
module spgd_queue #(
  parameter int ENTRY_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic [ENTRY_BITS-1:0]               push_data,
  input  logic                                pop,
  output logic                                not_empty,
  output logic [ENTRY_BITS-1:0]               pop_data,
  output logic [spgd_pkg::QUEUE_LVL_BITS-1:0] level
);

  localparam int PW = spgd_pkg::QUEUE_PTR_BITS;
  localparam int LW = spgd_pkg::QUEUE_LVL_BITS;

  logic [ENTRY_BITS-1:0] slot_r [spgd_pkg::QUEUE_DEPTH];
  logic [PW-1:0]         wr_ptr_r, rd_ptr_r;
  logic [LW-1:0]         level_r, level_nxt;

  // Track the fill level
  always_comb begin
    level_nxt = level_r;
    if (push && !pop) level_nxt = level_r + 1'b1;
    else if (!push && pop) level_nxt = level_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      level_r <= level_nxt;
    end
  end

  // Store the entry payload
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  assign pop_data  = slot_r[rd_ptr_r];
  assign not_empty = (level_r != '0);
  assign level     = level_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (level_r != LW'(spgd_pkg::QUEUE_DEPTH)) || pop)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue pop while empty");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(spgd_pkg::QUEUE_DEPTH))
    else $error("queue level beyond depth");

endmodule

FILE: rtl/spgd_back.sv
// Back part: walks one queued entry and emits its runs, even chain first.
// Output register decouples the result stream. Depends on spgd_pkg.
module spgd_back #(
  parameter int RUNS = 9
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_valid,
  input  logic [RUNS-1:0]                        q_even,
  input  logic [RUNS-1:0]                        q_odd,
  input  logic [RUNS*spgd_pkg::PRIME_BITS-1:0]   q_primes,
  output logic                                   q_pop,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [spgd_pkg::PRIME_BITS-1:0]        out_prime,
  output logic [spgd_pkg::PATTERN_BITS-1:0]      out_gaps,
  output logic                                   out_last
);

  localparam int PB = spgd_pkg::PRIME_BITS;
  localparam int KW = (RUNS > 1) ? $clog2(RUNS) : 1;

  logic                              busy_r;
  logic                              odd_r;
  logic [KW-1:0]                     k_r;
  logic [RUNS-1:0]                   cur_even_r, cur_odd_r;
  logic [PB-1:0]                     cur_prime_r [RUNS];
  logic                              out_valid_r;
  logic [PB-1:0]                     out_prime_r;
  logic [spgd_pkg::PATTERN_BITS-1:0] out_gaps_r;
  logic                              out_last_r;
  logic                              slot_free, emit;
  logic [RUNS-1:0]                   even_sh, odd_sh;
  logic                              next_even, next_odd, has_next;

  assign slot_free = !out_valid_r || out_tready;
  assign emit      = busy_r && slot_free;
  assign q_pop     = !busy_r && q_valid;

  // Look one run ahead to mark the final result
  assign even_sh   = cur_even_r >> 1;
  assign odd_sh    = cur_odd_r >> 1;
  assign next_even = even_sh[k_r];
  assign next_odd  = odd_sh[k_r];
  assign has_next  = odd_r ? next_odd : (next_even || cur_odd_r[0]);

  // Sequence through the runs of the current entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      odd_r       <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        odd_r  <= !q_even[0];
        k_r    <= '0;
      end else if (emit) begin
        if (!has_next) begin
          busy_r <= 1'b0;
        end else if (odd_r || next_even) begin
          k_r <= k_r + 1'b1;
        end else begin
          odd_r <= 1'b1;
          k_r   <= '0;
        end
      end
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Load the entry payload and the result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_even_r <= q_even;
      cur_odd_r  <= q_odd;
      for (int k = 0; k < RUNS; k++) cur_prime_r[k] <= q_primes[k*PB +: PB];
    end
    if (emit) begin
      out_prime_r <= cur_prime_r[k_r];
      out_gaps_r  <= spgd_pkg::PATTERN_BITS'(32'(spgd_pkg::BASE_GAPS) + 32'(odd_r)
                                             + (32'(k_r) << 1));
      out_last_r  <= !has_next;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_prime  = out_prime_r;
  assign out_gaps   = out_gaps_r;
  assign out_last   = out_last_r;

  a_emit_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r))
    else $error("result emitted with no entry in hand");

  a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !q_pop)
    else $error("entry popped while another is in progress");

endmodule

FILE: rtl/symmetric_prime_gap_detector.sv
// Top level of the symmetric prime gap detector: stream ports, front, queue, back.
// Depends on spgd_pkg, spgd_front, spgd_queue and spgd_back.
//
// Takes one prime per clock cycle on the in_ stream while in_tready is high and
// reports palindromic gap runs centred in the window of the last WINDOW_GAPS+1
// primes on the out_ stream, one result per cycle while out_tready is high, the
// last result of a prime marked with tlast. Results of a prime pass the window
// update, classification into the queue, the sequencer load and the output
// register; the sequencer idles while it loads the entry of the next prime.
// Input is held while the entries in the four-entry queue between the
// classifier and the sequencer, plus a prime still being classified, reach
// four, so a burst of primes with matches waiting unserved stalls the input.
// in_tuser restart clears the window before its prime is taken.
module symmetric_prime_gap_detector #(
  parameter int WINDOW_GAPS = spgd_pkg::DEF_WINDOW_GAPS,
  parameter int GAP_BITS    = spgd_pkg::DEF_GAP_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] prime_value
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [63:0] start_prime, [69:64] pattern_gaps, [71:70] zero
  output logic        out_tlast   // last_of_run
);

  localparam int RUNS = WINDOW_GAPS / 2 - spgd_pkg::INNER_SPAN;
  localparam int PB   = spgd_pkg::PRIME_BITS;
  localparam int EW   = RUNS * (PB + 2);

  logic                                push, pop, q_valid;
  logic [RUNS-1:0]                     f_even, f_odd, b_even, b_odd;
  logic [RUNS*PB-1:0]                  f_primes, b_primes;
  logic [EW-1:0]                       pop_data;
  logic [spgd_pkg::QUEUE_LVL_BITS-1:0] q_level;
  logic [PB-1:0]                       res_prime;
  logic [spgd_pkg::PATTERN_BITS-1:0]   res_gaps;

  spgd_front #(
    .WINDOW_GAPS (WINDOW_GAPS),
    .GAP_BITS    (GAP_BITS),
    .RUNS        (RUNS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_prime   (in_tdata),
    .in_restart (in_tuser),
    .q_level    (q_level),
    .q_push     (push),
    .q_even     (f_even),
    .q_odd      (f_odd),
    .q_primes   (f_primes)
  );

  spgd_queue #(
    .ENTRY_BITS (EW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_primes, f_odd, f_even}),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_data  (pop_data),
    .level     (q_level)
  );

  // Split the queue entry back into its fields
  assign b_even   = pop_data[RUNS-1:0];
  assign b_odd    = pop_data[2*RUNS-1:RUNS];
  assign b_primes = pop_data[EW-1:2*RUNS];

  spgd_back #(
    .RUNS (RUNS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_even     (b_even),
    .q_odd      (b_odd),
    .q_primes   (b_primes),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_prime  (res_prime),
    .out_gaps   (res_gaps),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, res_gaps, res_prime};

endmodule

FILE: sim/tb_symmetric_prime_gap_detector.sv
// Self-checking testbench for symmetric_prime_gap_detector: directed rows, then gap streams.
// Depends on rtl/spgd_pkg.sv and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_symmetric_prime_gap_detector;

  localparam int N_GAPS = spgd_pkg::DEF_WINDOW_GAPS;
  localparam int GAP_W = spgd_pkg::DEF_GAP_BITS;
  localparam int CENTRE = N_GAPS / 2 - 1;
  localparam logic [63:0] GAP_MAX = (64'd1 << GAP_W) - 64'd1;
  localparam int N_DIR = 24;

  typedef struct packed {
    logic [spgd_pkg::PRIME_BITS-1:0]   start;
    logic [spgd_pkg::PATTERN_BITS-1:0] gaps;
    logic                              last;
  } gap_run_t;

  typedef struct packed {
    logic [63:0] prime;
    logic        restart;
  } prime_item_t;

  typedef struct packed {
    logic [63:0] prime;
    logic        restart;
    logic [4:0]  runs;
  } dir_row_t;

  // Window never fills here, so every row expects no run
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{64'd0, 1'b1, 5'd0},
    '{64'd2, 1'b0, 5'd0},
    '{64'd3, 1'b0, 5'd0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 5'd0},
    '{64'd0, 1'b0, 5'd0},
    '{64'h0000_0000_0001_0000, 1'b0, 5'd0},
    '{64'h0000_0000_0001_FFFF, 1'b0, 5'd0},
    '{64'h0000_0000_0001_FFFE, 1'b0, 5'd0},
    '{64'h5555_5555_5555_5555, 1'b1, 5'd0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 5'd0},
    '{64'h8000_0000_0000_0000, 1'b0, 5'd0},
    '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 5'd0},
    '{64'd5, 1'b0, 5'd0},
    '{64'd7, 1'b0, 5'd0},
    '{64'd11, 1'b0, 5'd0},
    '{64'd13, 1'b0, 5'd0},
    '{64'd17, 1'b0, 5'd0},
    '{64'd19, 1'b0, 5'd0},
    '{64'd23, 1'b0, 5'd0},
    '{64'd29, 1'b0, 5'd0},
    '{64'd31, 1'b0, 5'd0},
    '{64'd37, 1'b0, 5'd0},
    '{64'd41, 1'b0, 5'd0},
    '{64'd43, 1'b0, 5'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [63:0] prime_value
  logic        in_tuser;   // [0] restart
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // [63:0] start_prime, [69:64] pattern_gaps, [71:70] zero
  logic        out_tlast;

  // Predicted window state
  logic [63:0]      win_prime [0:N_GAPS];
  logic [GAP_W-1:0] win_gap [0:N_GAPS-1];
  int unsigned      win_head;
  int unsigned      win_fill;

  gap_run_t pending_runs[$];
  int       typed_run_counts[$];
  int       items_sent = 0;
  int       mismatches = 0;
  bit       idle_enable = 1'b1;

  symmetric_prime_gap_detector u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_symmetric_prime_gap_detector NOT OK");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < 40)
      $display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void clear_window();
    for (int k = 0; k <= N_GAPS; k++) win_prime[k] = '0;
    for (int k = 0; k < N_GAPS; k++) win_gap[k] = '0;
    win_head = 0;
    win_fill = 0;
  endfunction

  function automatic logic [GAP_W-1:0] gap_from_oldest(input int unsigned pos);
    return win_gap[(win_head + pos) % N_GAPS];
  endfunction

  function automatic void log_run(input int unsigned pos, input int unsigned len);
    gap_run_t r;
    r.start = win_prime[pos];
    r.gaps  = spgd_pkg::PATTERN_BITS'(len);
    r.last  = 1'b0;
    pending_runs.push_back(r);
  endfunction

  // Walk one chain outwards from the centre; stop at the first unequal pair
  function automatic int scan_chain(input int unsigned odd);
    int unsigned j;
    int          hits;
    hits = 0;
    for (j = (odd != 0) ? 0 : 1; j <= spgd_pkg::INNER_SPAN; j++)
      if (gap_from_oldest(CENTRE - j) != gap_from_oldest(CENTRE + j + odd)) return 0;
    log_run(CENTRE - spgd_pkg::INNER_SPAN, spgd_pkg::BASE_GAPS + odd);
    hits = 1;
    for (j = spgd_pkg::INNER_SPAN + 1; j <= CENTRE; j++) begin
      if (gap_from_oldest(CENTRE - j) != gap_from_oldest(CENTRE + j + odd)) return hits;
      log_run(CENTRE - j, spgd_pkg::BASE_GAPS + odd + 2 * (j - spgd_pkg::INNER_SPAN));
      hits++;
    end
    return hits;
  endfunction

  // Take one prime into the window and queue the runs it reveals
  function automatic int advance_window(input logic [63:0] p, input logic restart);
    logic [63:0] step;
    int          found;
    gap_run_t    tail;
    if (restart) clear_window();
    if (win_fill > 0) begin
      step = p - win_prime[N_GAPS];
      if (step > GAP_MAX) step = GAP_MAX;
      win_gap[win_head] = step[GAP_W-1:0];
      win_head = (win_head + 1) % N_GAPS;
    end
    for (int k = 0; k < N_GAPS; k++) win_prime[k] = win_prime[k+1];
    win_prime[N_GAPS] = p;
    if (win_fill < N_GAPS + 1) win_fill++;
    if (win_fill < N_GAPS + 1) return 0;
    found = scan_chain(0);
    found += scan_chain(1);
    if (found > 0) begin
      tail = pending_runs.pop_back();
      tail.last = 1'b1;
      pending_runs.push_back(tail);
    end
    return found;
  endfunction

  // Mostly small even gaps, now and then a gap of one or one that saturates
  function automatic logic [63:0] pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 64'd65536 + 64'($urandom_range(0, 200000));
    if (sel == 1) return 64'd1;
    return 64'($urandom_range(1, 30)) * 64'd2;
  endfunction

  task automatic send_prime(input logic [63:0] p, input logic restart);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    in_tuser  <= restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Check results and advance the predictor on each handshake
  always @(posedge clk) begin
    gap_run_t want;
    int       n;
    int       want_n;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_runs.size() == 0) begin
          flag_mismatch("result with none pending", out_tdata[63:0], 64'd0);
        end else begin
          want = pending_runs.pop_front();
          if (out_tdata[63:0] != want.start)
            flag_mismatch("start_prime", out_tdata[63:0], want.start);
          if (out_tdata[69:64] != want.gaps)
            flag_mismatch("pattern_gaps", 64'(out_tdata[69:64]), 64'(want.gaps));
          if (out_tlast != want.last)
            flag_mismatch("last_of_run", 64'(out_tlast), 64'(want.last));
          if (out_tdata[71:70] != 2'b00)
            flag_mismatch("tdata padding", 64'(out_tdata[71:70]), 64'd0);
        end
      end
      if (in_tvalid && in_tready) begin
        n = advance_window(in_tdata, in_tuser);
        want_n = typed_run_counts.pop_front();
        if (want_n >= 0 && n != want_n)
          flag_mismatch("runs for directed row", 64'(n), 64'(want_n));
      end
    end
  end

  // Result side back-pressure in short bursts
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin
    prime_item_t seg[$];
    prime_item_t item;
    logic [63:0] g [N_GAPS];
    logic [63:0] cur;
    logic [63:0] v;
    int unsigned kind, shape, brk, lo, hi, n;
    bit          first_seg;

    clear_window();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: extremes, wrap-around, saturation and restart mid-fill
    for (int r = 0; r < N_DIR; r++) begin
      typed_run_counts.push_back(int'(DIR_ROWS[r].runs));
      send_prime(DIR_ROWS[r].prime, DIR_ROWS[r].restart);
    end

    // Random gap streams, mostly windows built to be symmetric
    cur = 64'd1000003;
    first_seg = 1'b1;
    while (items_sent < 160) begin
      idle_enable = (items_sent < 140) && ($urandom_range(0, 3) != 0);
      kind = first_seg ? 0 : $urandom_range(0, 9);
      if (kind <= 4) begin
        shape = $urandom_range(0, 2);
        if (first_seg || $urandom_range(0, 3) == 0) begin
          cur = {$urandom, $urandom} >> $urandom_range(0, 63);
          seg.push_back('{cur, 1'b1});
        end
        if (shape == 2) begin
          v = pick_gap();
          for (int i = 0; i < N_GAPS; i++) g[i] = v;
        end else if (shape == 0) begin
          for (int i = 0; i <= CENTRE; i++) begin
            v = pick_gap();
            g[i] = v;
            // A different saturating gap still mirrors a saturating one
            g[N_GAPS-1-i] = (v > GAP_MAX) ? 64'd65536 + 64'($urandom_range(0, 300000)) : v;
          end
        end else begin
          g[CENTRE] = pick_gap();
          g[N_GAPS-1] = pick_gap();
          for (int j = 1; j <= CENTRE; j++) begin
            v = pick_gap();
            g[CENTRE-j] = v;
            g[CENTRE+j] = v;
          end
        end
        // Break the mirror at a random depth, or leave it whole
        brk = $urandom_range(0, 19);
        if (brk <= CENTRE && !(shape == 1 && brk == 0)) begin
          lo = CENTRE - brk;
          hi = (shape == 1) ? CENTRE + brk : CENTRE + 1 + brk;
          g[hi] = (g[lo] > 64'd60) ? 64'd4 : g[lo] + 64'd2;
        end
        for (int i = 0; i < N_GAPS; i++) begin
          cur = cur + g[i];
          seg.push_back('{cur, 1'b0});
        end
        repeat ($urandom_range(0, 3)) begin
          cur = cur + pick_gap();
          seg.push_back('{cur, 1'b0});
        end
      end else if (kind <= 6) begin
        // Equal gaps throughout: each window that holds only these gaps gives the most runs
        v = pick_gap();
        if ($urandom_range(0, 1) == 0) seg.push_back('{cur, 1'b1});
        n = $urandom_range(33, 36);
        repeat (n) begin
          cur = cur + v;
          seg.push_back('{cur, 1'b0});
        end
      end else if (kind <= 8) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: begin
              cur = {$urandom, $urandom};
              seg.push_back('{cur, 1'b0});
            end
            1: begin
              cur = {$urandom, $urandom};
              seg.push_back('{cur, 1'b1});
            end
            default: begin
              cur = cur + pick_gap();
              seg.push_back('{cur, 1'b0});
            end
          endcase
        end
      end else begin
        // Run across the top of the 64-bit range
        cur = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 100));
        seg.push_back('{cur, 1'b0});
        repeat ($urandom_range(4, 10)) begin
          cur = cur + pick_gap();
          seg.push_back('{cur, 1'b0});
        end
      end
      first_seg = 1'b0;
      while (seg.size() > 0) begin
        item = seg.pop_front();
        typed_run_counts.push_back(-1);
        send_prime(item.prime, item.restart);
      end
    end
    in_tvalid <= 1'b0;

    // Drain, then keep clocking so that stray results can still show
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_symmetric_prime_gap_detector OK");
    end else begin
      $display("tb_symmetric_prime_gap_detector NOT OK");
    end
    $finish;
  end

endmodule
